[rtl/core/lwct_pkg.sv]
package lwct_pkg;

  localparam int unsigned LBA_W      = 32;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned RCOUNT_W   = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned BIT_CNT_W  = 5;

  localparam int unsigned RING_INDEX_BITS_DEF = 8;

  localparam logic [REG_IDX_W-1:0] REG_DATA_START = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CARD_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RING_START = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RING_COUNT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STALL_TH   = 3'd5;

  localparam logic [LBA_W-1:0]      DATA_START_RST = 32'd32;
  localparam logic [LBA_W-1:0]      CARD_COUNT_RST = 32'd4194304;
  localparam logic [LBA_W-1:0]      RING_START_RST = 32'd0;
  localparam logic [RCOUNT_W-1:0]   RING_COUNT_RST = 8'd32;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 16'd16;
  localparam logic [MS_W-1:0]       STALL_TH_RST   = 32'd20;

endpackage

[rtl/core/lwct_ifs.sv]
interface lwct_commit_if import lwct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LBA_W-1:0] wr_lba;
  logic [MS_W-1:0]  elapsed_ms;
  logic             checkpoint_written;

  modport source (output valid, wr_lba, elapsed_ms, checkpoint_written, input ready);
  modport sink (input valid, wr_lba, elapsed_ms, checkpoint_written, output ready);
endinterface

interface lwct_report_if import lwct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LBA_W-1:0] next_lba;
  logic [SEQ_W-1:0] commit_seq;
  logic [MS_W-1:0]  worst_total_ms;
  logic [SEQ_W-1:0] stalls_seen;
  logic [LBA_W-1:0] checkpoint_lba;
  logic             checkpoint_due;

  modport source (output valid, next_lba, commit_seq, worst_total_ms, stalls_seen,
                  checkpoint_lba, checkpoint_due, input ready);
  modport sink (input valid, next_lba, commit_seq, worst_total_ms, stalls_seen,
                checkpoint_lba, checkpoint_due, output ready);
endinterface

[rtl/core/log_write_commit_tracker.sv]
// one item at a time: a new item is accepted only when idle, after the previous item
//   has run two bit-serial passes (address, compares and sequence counter lsb first,
//   then a radix-2 modulo msb first with the stall counter lsb first)
// the output register lets the next item start while a result waits
// reset: synchronous, clears counters and ring slot, configuration registers
//   to their documented defaults
module log_write_commit_tracker import lwct_pkg::*; #(
  parameter int unsigned RING_INDEX_BITS = RING_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lwct_commit_if.sink        commit,
  lwct_report_if.source      report,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned CMP_W = (RING_INDEX_BITS > RCOUNT_W) ? RING_INDEX_BITS : RCOUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [LBA_W-1:0]      data_base;
  logic [LBA_W-1:0]      card_size;
  logic [LBA_W-1:0]      ring_start_lba;
  logic [RCOUNT_W-1:0]   ring_count;
  logic [INTERVAL_W-1:0] checkpoint_interval;
  logic [MS_W-1:0]       stall_limit;

  logic [SEQ_W-1:0]           seq_count;
  logic [MS_W-1:0]            worst_time;
  logic [SEQ_W-1:0]           stall_total;
  logic [RING_INDEX_BITS-1:0] ring_slot;

  logic [1:0]           state;
  logic [BIT_CNT_W-1:0] cnt;

  logic [LBA_W-1:0]           lba_sh;
  logic [MS_W-1:0]            ms_sh;
  logic [LBA_W-1:0]           addr_sh;
  logic [SEQ_W-1:0]           seq_sh;
  logic [SEQ_W-1:0]           d_sh;
  logic [LBA_W-1:0]           cp_sh;
  logic [SEQ_W-1:0]           stall_sh;
  logic [RING_INDEX_BITS-1:0] slot_new;
  logic [INTERVAL_W-1:0]      rem;

  logic ca, cs, cd, cr, ci;
  logic lt_ds, lt_card, gt_w, lt_th;

  logic [RING_INDEX_BITS-1:0] slot_inc;
  logic [RING_INDEX_BITS-1:0] slot_next;
  logic [LBA_W-1:0]           slot_ext;
  logic                       ab, sb1, db1, rb, msb, stb;
  logic [INTERVAL_W:0]        rem_sh;
  logic                       wr_en;

  // less-than flag including the msb compared in the same cycle
  function automatic logic lt_th_final(input logic lt, input logic a, input logic b);
    logic r;
    r = lt;
    if (a != b) r = b;
    return r;
  endfunction

  assign pready       = 1'b1;
  assign wr_en        = psel & penable & pwrite;
  assign commit.ready = (state == ST_IDLE);

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_DATA_START: prdata = data_base;
      REG_CARD_COUNT: prdata = card_size;
      REG_RING_START: prdata = ring_start_lba;
      REG_RING_COUNT: prdata = DATA_W'(ring_count);
      REG_INTERVAL:   prdata = DATA_W'(checkpoint_interval);
      REG_STALL_TH:   prdata = stall_limit;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base           <= DATA_START_RST;
      card_size           <= CARD_COUNT_RST;
      ring_start_lba      <= RING_START_RST;
      ring_count          <= RING_COUNT_RST;
      checkpoint_interval <= INTERVAL_RST;
      stall_limit         <= STALL_TH_RST;
    end else if (wr_en) begin
      unique case (paddr[PADDR_W-1:2])
        REG_DATA_START: data_base           <= pwdata;
        REG_CARD_COUNT: card_size           <= pwdata;
        REG_RING_START: ring_start_lba      <= pwdata;
        REG_RING_COUNT: ring_count          <= pwdata[RCOUNT_W-1:0];
        REG_INTERVAL:   checkpoint_interval <= pwdata[INTERVAL_W-1:0];
        REG_STALL_TH:   stall_limit         <= pwdata;
        default: ;
      endcase
    end
  end

  // ring slot step, narrow enough to do at accept
  always_comb begin
    slot_inc  = ring_slot + 1'b1;
    slot_next = ring_slot;
    if (commit.checkpoint_written && (ring_count != '0)) begin
      if (CMP_W'(slot_inc) >= CMP_W'(ring_count)) begin
        slot_next = '0;
      end else begin
        slot_next = slot_inc;
      end
    end
  end

  // one bit of each serial datapath
  always_comb begin
    slot_ext = LBA_W'(slot_new);
    ab       = lba_sh[0] ^ ca;
    msb      = ms_sh[0];
    sb1      = seq_count[cnt] ^ cs;
    db1      = sb1 ^ cd;
    rb       = ring_start_lba[cnt] ^ slot_ext[cnt] ^ cr;
    stb      = stall_total[cnt] ^ ci;
    rem_sh   = {rem, d_sh[SEQ_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      report.valid <= 1'b0;
      seq_count    <= '0;
      worst_time   <= '0;
      stall_total  <= '0;
      ring_slot    <= '0;
    end else begin
      if (report.valid && report.ready && (state != ST_FIN)) begin
        report.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (commit.valid) begin
            lba_sh   <= commit.wr_lba;
            ms_sh    <= commit.elapsed_ms;
            slot_new <= slot_next;
            ca       <= 1'b1;
            cs       <= 1'b1;
            cd       <= 1'b1;
            cr       <= 1'b0;
            lt_ds    <= 1'b0;
            lt_card  <= 1'b0;
            gt_w     <= 1'b0;
            lt_th    <= 1'b0;
            cnt      <= '0;
            state    <= ST_ADD;
          end
        end
        ST_ADD: begin
          lba_sh  <= {1'b0, lba_sh[LBA_W-1:1]};
          ms_sh   <= {msb, ms_sh[MS_W-1:1]};
          addr_sh <= {ab, addr_sh[LBA_W-1:1]};
          seq_sh  <= {sb1, seq_sh[SEQ_W-1:1]};
          d_sh    <= {db1, d_sh[SEQ_W-1:1]};
          cp_sh   <= {rb, cp_sh[LBA_W-1:1]};
          ca      <= lba_sh[0] & ca;
          cs      <= seq_count[cnt] & cs;
          cd      <= sb1 & cd;
          cr      <= (ring_start_lba[cnt] & slot_ext[cnt]) |
                     (cr & (ring_start_lba[cnt] ^ slot_ext[cnt]));
          if (ab != data_base[cnt]) lt_ds <= data_base[cnt];
          if (ab != card_size[cnt]) lt_card <= card_size[cnt];
          if (msb != worst_time[cnt]) gt_w <= msb;
          if (msb != stall_limit[cnt]) lt_th <= stall_limit[cnt];
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            rem   <= '0;
            ci    <= ~lt_th_final(lt_th, msb, stall_limit[cnt]);
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          d_sh     <= {d_sh[SEQ_W-2:0], 1'b0};
          stall_sh <= {stb, stall_sh[SEQ_W-1:1]};
          ci       <= stall_total[cnt] & ci;
          if (rem_sh >= {1'b0, checkpoint_interval}) begin
            rem <= INTERVAL_W'(rem_sh - {1'b0, checkpoint_interval});
          end else begin
            rem <= rem_sh[INTERVAL_W-1:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!report.valid || report.ready) begin
            seq_count   <= seq_sh;
            worst_time  <= gt_w ? ms_sh : worst_time;
            stall_total <= stall_sh;
            ring_slot   <= slot_new;

            report.valid          <= 1'b1;
            report.next_lba       <= (lt_ds || !lt_card) ? data_base : addr_sh;
            report.commit_seq     <= seq_sh;
            report.worst_total_ms <= gt_w ? ms_sh : worst_time;
            report.stalls_seen    <= stall_sh;
            report.checkpoint_lba <= (ring_count == '0) ? '0 : cp_sh;
            report.checkpoint_due <= (checkpoint_interval != '0) && (rem == '0);
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[test/commit_report_checker.sv]
`timescale 1ns / 100ps

module commit_report_checker import lwct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lwct_commit_if             commit,
  lwct_report_if             report,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  localparam int unsigned SLOT_W = RING_INDEX_BITS_DEF;
  localparam int unsigned SHOWN_MAX = 10;

  typedef struct packed {
    logic [LBA_W-1:0] next_lba;
    logic [SEQ_W-1:0] seq;
    logic [MS_W-1:0]  worst;
    logic [SEQ_W-1:0] stalls;
    logic [LBA_W-1:0] ckpt_lba;
    logic             ckpt_due;
  } commit_report_t;

  logic [LBA_W-1:0]      data_start;
  logic [LBA_W-1:0]      card_blocks;
  logic [LBA_W-1:0]      ring_base;
  logic [RCOUNT_W-1:0]   ring_slots;
  logic [INTERVAL_W-1:0] ckpt_every;
  logic [MS_W-1:0]       stall_limit;

  logic [LBA_W-1:0]      next_lba_q;
  logic [SEQ_W-1:0]      seq_q;
  logic [MS_W-1:0]       worst_q;
  logic [SEQ_W-1:0]      stall_q;
  logic [SLOT_W-1:0]     slot_q;

  commit_report_t        reports_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    fail_count++;
    if (fail_count <= SHOWN_MAX) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      note_failure(what, want, got);
    end
  endfunction

  function automatic commit_report_t track_commit(input logic [LBA_W-1:0] lba,
                                                  input logic [MS_W-1:0] ms,
                                                  input logic ck);
    commit_report_t r;
    logic [LBA_W-1:0] bumped;
    bumped = lba + 32'd1;
    next_lba_q = (bumped < data_start || bumped >= card_blocks) ? data_start : bumped;
    if (ms > worst_q) begin
      worst_q = ms;
    end
    if (ms >= stall_limit) begin
      stall_q = stall_q + 32'd1;
    end
    if (ck && ring_slots != '0) begin
      slot_q = slot_q + 1'b1;
      if (slot_q >= ring_slots) begin
        slot_q = '0;
      end
    end
    seq_q = seq_q + 32'd1;
    r.next_lba = next_lba_q;
    r.seq      = seq_q;
    r.worst    = worst_q;
    r.stalls   = stall_q;
    r.ckpt_lba = (ring_slots == '0) ? '0 : ring_base + LBA_W'(slot_q);
    r.ckpt_due = (ckpt_every != '0) && (((seq_q + 32'd1) % ckpt_every) == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    commit_report_t want;
    logic [DATA_W-1:0] reg_now;
    logic known;
    if (rst) begin
      data_start  = DATA_START_RST;
      card_blocks = CARD_COUNT_RST;
      ring_base   = RING_START_RST;
      ring_slots  = RING_COUNT_RST;
      ckpt_every  = INTERVAL_RST;
      stall_limit = STALL_TH_RST;
      next_lba_q  = DATA_START_RST;
      seq_q       = '0;
      worst_q     = '0;
      stall_q     = '0;
      slot_q      = '0;
      reports_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_DATA_START: data_start  = pwdata;
            REG_CARD_COUNT: card_blocks = pwdata;
            REG_RING_START: ring_base   = pwdata;
            REG_RING_COUNT: ring_slots  = pwdata[RCOUNT_W-1:0];
            REG_INTERVAL:   ckpt_every  = pwdata[INTERVAL_W-1:0];
            REG_STALL_TH:   stall_limit = pwdata;
            default: ;
          endcase
        end else begin
          known = 1'b1;
          reg_now = '0;
          case (paddr[PADDR_W-1:2])
            REG_DATA_START: reg_now = data_start;
            REG_CARD_COUNT: reg_now = card_blocks;
            REG_RING_START: reg_now = ring_base;
            REG_RING_COUNT: reg_now = DATA_W'(ring_slots);
            REG_INTERVAL:   reg_now = DATA_W'(ckpt_every);
            REG_STALL_TH:   reg_now = stall_limit;
            default:        known = 1'b0;
          endcase
          if (known) begin
            check_field("register read", reg_now, prdata);
          end
        end
      end
      if (commit.valid && commit.ready) begin
        reports_due.push_back(track_commit(commit.wr_lba, commit.elapsed_ms,
                                           commit.checkpoint_written));
      end
      if (report.valid && report.ready) begin
        if (reports_due.size() == 0) begin
          note_failure("report item with none due", '0, report.commit_seq);
        end else begin
          want = reports_due.pop_front();
          check_field("next_lba", want.next_lba, report.next_lba);
          check_field("commit_seq", want.seq, report.commit_seq);
          check_field("worst_total_ms", want.worst, report.worst_total_ms);
          check_field("stalls_seen", want.stalls, report.stalls_seen);
          check_field("checkpoint_lba", want.ckpt_lba, report.checkpoint_lba);
          check_field("checkpoint_due", 32'(want.ckpt_due), 32'(report.checkpoint_due));
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lwct_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [REG_IDX_W-1:0] KNOWN_REGS [6] = '{REG_DATA_START, REG_CARD_COUNT,
      REG_RING_START, REG_RING_COUNT, REG_INTERVAL, REG_STALL_TH};
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        pending;

  bit                 hold_long_req = 1'b0;
  bit                 quiet = 1'b0;
  int unsigned        idle_pct = 20;
  logic [LBA_W-1:0]   cfg_start = DATA_START_RST;
  logic [LBA_W-1:0]   cfg_card = CARD_COUNT_RST;
  logic [MS_W-1:0]    cfg_thr = STALL_TH_RST;

  lwct_commit_if commit_ch ();
  lwct_report_if report_ch ();

  always #4 clk = ~clk;

  log_write_commit_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .commit  (commit_ch),
    .report  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  commit_report_checker report_check (
    .clk        (clk),
    .rst        (rst),
    .commit     (commit_ch),
    .report     (report_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DATA_START: cfg_start = val;
      REG_CARD_COUNT: cfg_card = val;
      REG_STALL_TH:   cfg_thr = val;
      default: ;
    endcase
  endtask

  task automatic read_back();
    foreach (KNOWN_REGS[i]) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {KNOWN_REGS[i], 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_config(input logic [31:0] start, input logic [31:0] card,
                             input logic [31:0] base, input logic [31:0] slots,
                             input logic [31:0] every, input logic [31:0] thr);
    reg_write(REG_DATA_START, start);
    reg_write(REG_CARD_COUNT, card);
    reg_write(REG_RING_START, base);
    reg_write(REG_RING_COUNT, slots);
    reg_write(REG_INTERVAL, every);
    reg_write(REG_STALL_TH, thr);
    read_back();
  endtask

  task automatic send_commit(input logic [LBA_W-1:0] lba, input logic [MS_W-1:0] ms,
                             input logic ck);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      commit_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    commit_ch.valid              <= 1'b1;
    commit_ch.wr_lba             <= lba;
    commit_ch.elapsed_ms         <= ms;
    commit_ch.checkpoint_written <= ck;
    do @(posedge clk); while (!commit_ch.ready);
  endtask

  // wait until every report is back, then idle on spare cycles before returning
  task automatic settle();
    commit_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_commit();
    logic [LBA_W-1:0] lba;
    logic [MS_W-1:0]  ms;
    case ($urandom_range(0, 5))
      0: lba = $urandom;
      1: lba = cfg_start + $urandom_range(0, 4) - 32'd2;
      2: lba = cfg_card + $urandom_range(0, 4) - 32'd3;
      3: lba = ALL_ONES - $urandom_range(0, 1);
      default: lba = cfg_start + $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 3))
      0: ms = $urandom;
      1: ms = cfg_thr + $urandom_range(0, 2) - 32'd1;
      default: ms = $urandom_range(0, 200);
    endcase
    send_commit(lba, ms, $urandom_range(0, 1) == 1);
  endtask

  task automatic random_config();
    logic [31:0] start;
    logic [31:0] card;
    logic [31:0] base;
    logic [31:0] slots;
    logic [31:0] every;
    logic [31:0] thr;
    case ($urandom_range(0, 5))
      0: start = '0;
      1: start = $urandom;
      2: start = ALL_ONES;
      default: start = $urandom_range(0, 5000);
    endcase
    case ($urandom_range(0, 5))
      0: card = $urandom;
      1: card = ALL_ONES;
      2: card = start;
      3: card = start + $urandom_range(1, 64);
      default: card = start + $urandom_range(0, 3000);
    endcase
    base = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1000);
    case ($urandom_range(0, 4))
      0: slots = 0;
      1: slots = 1;
      2: slots = 255;
      default: slots = $urandom_range(2, 40);
    endcase
    case ($urandom_range(0, 4))
      0: every = 0;
      1: every = 1;
      2: every = 32'h0000_FFFF;
      default: every = $urandom_range(2, 20);
    endcase
    case ($urandom_range(0, 4))
      0: thr = 0;
      1: thr = ALL_ONES;
      2: thr = $urandom;
      default: thr = $urandom_range(0, 200);
    endcase
    load_config(start, card, base, slots, every, thr);
  endtask

  initial begin
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long_req) begin
        hold_long_req = 1'b0;
        report_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        report_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        report_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        report_ch.ready <= 1'b1;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst                          <= 1'b1;
    psel                         <= 1'b0;
    penable                      <= 1'b0;
    pwrite                       <= 1'b0;
    paddr                        <= '0;
    pwdata                       <= '0;
    commit_ch.valid              <= 1'b0;
    commit_ch.wr_lba             <= '0;
    commit_ch.elapsed_ms         <= '0;
    commit_ch.checkpoint_written <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_back();

    // reset settings: address wrap below start, at card end, add overflow
    send_commit(32'd0, 32'd0, 1'b0);
    send_commit(ALL_ONES, ALL_ONES, 1'b1);
    send_commit(32'd31, 32'd19, 1'b0);
    send_commit(32'd30, 32'd20, 1'b1);
    send_commit(32'd4194302, 32'd21, 1'b0);
    send_commit(32'd4194303, 32'd0, 1'b1);
    send_commit(32'd100, 32'h8000_0000, 1'b0);
    send_commit(32'h7FFF_FFFF, 32'd1, 1'b1);
    settle();

    // start above card size, empty ring, zero interval, zero threshold
    load_config(32'd100, 32'd50, 32'd0, 32'd0, 32'd0, 32'd0);
    send_commit(32'd100, 32'd0, 1'b1);
    send_commit(32'd49, 32'd5, 1'b1);
    send_commit(ALL_ONES, 32'd0, 1'b0);
    settle();

    // ring base wrap, then shrink ring below the current slot
    load_config(32'd0, ALL_ONES, 32'hFFFF_FFFE, 32'd10, 32'd1, ALL_ONES);
    send_commit(32'hFFFF_FFFE, ALL_ONES, 1'b1);
    send_commit(32'hFFFF_FFFD, 32'd0, 1'b1);
    send_commit(32'd0, 32'hFFFF_FFFE, 1'b1);
    send_commit(32'd5, ALL_ONES, 1'b1);
    settle();
    reg_write(REG_RING_COUNT, 32'd3);
    reg_write(REG_SPARE_LO, ALL_ONES);
    reg_write(REG_SPARE_HI, ALL_ONES);
    read_back();
    send_commit(32'd7, 32'd3, 1'b1);
    send_commit(32'd8, 32'd4, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        load_config(32'd0, ALL_ONES, ALL_ONES, 32'd255, 32'h0000_FFFF, 32'd0);
      end else if (p == 1) begin
        load_config(ALL_ONES, 32'd0, 32'd0, 32'd1, 32'd2, ALL_ONES);
      end else begin
        random_config();
      end
      idle_pct = (p == 3) ? 0 : $urandom_range(5, 40);
      hold_long_req = (p == 2);
      quiet = (p == PHASES - 1);
      repeat (PHASE_ITEMS) random_commit();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
